// ----- hdl/vdt_pkg.sv -----
// Package with the sizes and types shared by the vertex dedup table files.
package vdt_pkg;

    localparam int VERTEX_DEPTH = 256;
    localparam int COORD_W      = 16;
    localparam int VERTEX_W     = 3 * COORD_W;
    localparam int INDEX_W      = 9;
    localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
    localparam int COUNT_W      = $clog2(VERTEX_DEPTH + 1);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [VERTEX_W-1:0]       vertex_t;
    typedef logic [INDEX_W-1:0]        entry_index_t;
    typedef logic [ADDR_W-1:0]         addr_t;
    typedef logic [COUNT_W-1:0]        count_t;

endpackage

// ----- hdl/vdt_if.sv -----
// Valid/ready channel interfaces for the vertex request and the lookup result.
interface vdt_req_if
    import vdt_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t coord_x;
    coord_t coord_y;
    coord_t coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    output ready);
endinterface

interface vdt_rsp_if
    import vdt_pkg::*;
();
    logic         valid;
    logic         ready;
    entry_index_t entry_index;
    logic         newly_added;
    logic         table_full;

    modport source (output valid, output entry_index, output newly_added,
                    output table_full, input ready);
    modport sink   (input valid, input entry_index, input newly_added,
                    input table_full, output ready);
endinterface

// ----- hdl/vertex_dedup_table_unit.sv -----
// Top level of the vertex dedup table: sequential find-or-insert over a vertex RAM.
//
// Each request beat carries one vertex; the unit scans the stored vertices
// from index 0 through its single RAM read port, one entry per cycle, and
// answers with the index of the first exact match, or appends the vertex and
// flags it as new, or flags the table as full when no entry is left. A request
// passes through these steps: the beat is taken; the stored vertices are
// scanned, where the RAM read is registered, so each compare comes in the cycle
// after its read; and the result is handed to the output register. That last
// step waits for as long as the previous result beat still sits untaken in the
// output register. The input is not ready while a request is in work, but it
// is ready again as soon as the result sits in the output register, even if
// the result beat has not been taken yet. The store needs no clearing after
// reset: only entries below the count are ever read.
module vertex_dedup_table_unit
    import vdt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    vdt_req_if.sink   req,
    vdt_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t       state_reg, state_next;
    count_t       count_reg, count_next;
    count_t       scan_addr_reg, scan_addr_next;
    logic         cmp_valid_reg, cmp_valid_next;
    vertex_t      key_reg, key_next;
    entry_index_t res_index_reg, res_index_next;
    logic         res_new_reg, res_new_next;
    logic         res_full_reg, res_full_next;
    logic         out_valid_reg, out_valid_next;
    entry_index_t out_index_reg, out_index_next;
    logic         out_new_reg, out_new_next;
    logic         out_full_reg, out_full_next;

    logic    rd_en;
    vertex_t rd_data;
    logic    wr_en;
    logic    match;
    logic    at_full;
    logic    out_free;

    vdt_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (VERTEX_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (scan_addr_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.entry_index = out_index_reg;
    assign rsp.newly_added = out_new_reg;
    assign rsp.table_full  = out_full_reg;

    // The one comparator of the unit: the key against the entry read last cycle.
    assign match    = cmp_valid_reg && (rd_data == key_reg);
    assign at_full  = (count_reg == COUNT_W'(VERTEX_DEPTH));
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_addr_next = scan_addr_reg;
        cmp_valid_next = 1'b0;
        key_next       = key_reg;
        res_index_next = res_index_reg;
        res_new_next   = res_new_reg;
        res_full_next  = res_full_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_new_next   = out_new_reg;
        out_full_next  = out_full_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    key_next       = {req.coord_x, req.coord_y, req.coord_z};
                    scan_addr_next = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    // The entry compared now was read at the previous address.
                    res_index_next = entry_index_t'(scan_addr_reg - count_t'(1));
                    res_new_next   = 1'b0;
                    res_full_next  = 1'b0;
                    state_next     = ST_DONE;
                end
                else if (scan_addr_reg == count_reg)
                begin
                    res_index_next = entry_index_t'(count_reg);
                    res_new_next   = !at_full;
                    res_full_next  = at_full;
                    if (!at_full)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + count_t'(1);
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en          = 1'b1;
                    cmp_valid_next = 1'b1;
                    scan_addr_next = scan_addr_reg + count_t'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = res_index_reg;
                    out_new_next   = res_new_reg;
                    out_full_next  = res_full_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_addr_reg <= '0;
            cmp_valid_reg <= 1'b0;
            key_reg       <= '0;
            res_index_reg <= '0;
            res_new_reg   <= 1'b0;
            res_full_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_new_reg   <= 1'b0;
            out_full_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_addr_reg <= scan_addr_next;
            cmp_valid_reg <= cmp_valid_next;
            key_reg       <= key_next;
            res_index_reg <= res_index_next;
            res_new_reg   <= res_new_next;
            res_full_reg  <= res_full_next;
            out_valid_reg <= out_valid_next;
            out_index_reg <= out_index_next;
            out_new_reg   <= out_new_next;
            out_full_reg  <= out_full_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(VERTEX_DEPTH))
        else $error("vertex count exceeds the store depth");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_new_reg && out_full_reg))
        else $error("result is flagged both new and full");

    a_hit_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_new_reg && !out_full_reg)
            |-> (COUNT_W'(out_index_reg) < count_reg))
        else $error("hit index is not below the vertex count");

    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_full_reg) |-> at_full)
        else $error("full flag while the store has room");

    a_append_bumps_count: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == $past(count_reg) + count_t'(1)))
        else $error("append did not advance the vertex count");
`endif

endmodule

// ----- hdl/vdt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module vdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- tb/sv/tb_vertex_dedup_table_unit.sv -----
// Self-checking testbench for the vertex dedup table: random and corner vertices against a model.
module tb_vertex_dedup_table_unit;
    import vdt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     RANDOM_BEATS = 500;
    localparam int     STALL_LIMIT  = 6000;
    localparam coord_t COORD_MIN    = 16'sh8000;
    localparam coord_t COORD_MAX    = 16'sh7FFF;

    typedef struct packed {
        entry_index_t entry_index;
        logic         newly_added;
        logic         table_full;
    } lookup_t;

    logic clk;
    logic rst_n;

    vdt_req_if req ();
    vdt_rsp_if rsp ();

    vertex_dedup_table_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    vertex_t vertex_backlog[$];
    lookup_t expected_lookups[$];

    // Shadow copy of the table contents and fill level.
    vertex_t model_store[VERTEX_DEPTH];
    int      stored_count;

    int total_beats;
    int beats_sent;
    int results_seen;
    int mismatch_count;
    int stall_cycles;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Scan the stored vertices in order; append on a miss if there is room.
    function automatic lookup_t find_or_insert(vertex_t key);
        lookup_t found;
        bit      hit;
        found = '0;
        hit   = 1'b0;
        for (int i = 0; i < stored_count && !hit; i++) begin
            if (model_store[i] == key) begin
                found.entry_index = entry_index_t'(i);
                hit = 1'b1;
            end
        end
        if (!hit) begin
            found.entry_index = entry_index_t'(stored_count);
            if (stored_count >= VERTEX_DEPTH) begin
                found.table_full = 1'b1;
            end
            else begin
                model_store[stored_count] = key;
                found.newly_added = 1'b1;
                stored_count++;
            end
        end
        return found;
    endfunction

    // The run is cut in three equal parts: sender idles lightly, then the
    // receiver does, then nobody idles.
    function automatic int run_phase(int beats_done);
        int p;
        p = (total_beats == 0) ? 0 : beats_done * 3 / total_beats;
        return (p > 2) ? 2 : p;
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(7))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return coord_t'(0);
            3: return coord_t'(-1);
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic check_field(string field, int expected, int actual);
        if (expected != actual) begin
            $display("%0t: %s expected %0d actual %0d", $realtime, field, expected, actual);
            mismatch_count++;
        end
    endtask

    // Driver: holds a beat until it is taken, predicting its result on acceptance.
    always @(posedge clk or negedge rst_n) begin : drive_requests
        vertex_t next_vertex;
        int      idle_pct;
        if (!rst_n) begin
            req.valid   <= 1'b0;
            req.coord_x <= '0;
            req.coord_y <= '0;
            req.coord_z <= '0;
        end
        else begin
            if (req.valid && req.ready) begin
                expected_lookups.push_back(
                    find_or_insert({req.coord_x, req.coord_y, req.coord_z}));
                beats_sent++;
            end
            if (!req.valid || req.ready) begin
                case (run_phase(beats_sent))
                    0:       idle_pct = 7;
                    1:       idle_pct = 52;
                    default: idle_pct = 0;
                endcase
                if (vertex_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    next_vertex = vertex_backlog.pop_front();
                    req.valid   <= 1'b1;
                    req.coord_x <= next_vertex[VERTEX_W-1 -: COORD_W];
                    req.coord_y <= next_vertex[2*COORD_W-1 -: COORD_W];
                    req.coord_z <= next_vertex[COORD_W-1:0];
                end
                else begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat against the oldest prediction.
    always @(posedge clk or negedge rst_n) begin : watch_results
        lookup_t expected;
        int      idle_pct;
        if (!rst_n) begin
            rsp.ready <= 1'b0;
        end
        else begin
            if (rsp.valid && rsp.ready) begin
                if (expected_lookups.size() == 0) begin
                    $display("%0t: unexpected result beat, index %0d new %0b full %0b",
                             $realtime, rsp.entry_index, rsp.newly_added, rsp.table_full);
                    mismatch_count++;
                end
                else begin
                    expected = expected_lookups.pop_front();
                    check_field("entry_index", expected.entry_index, rsp.entry_index);
                    check_field("newly_added", expected.newly_added, rsp.newly_added);
                    check_field("table_full", expected.table_full, rsp.table_full);
                end
                results_seen++;
            end
            case (run_phase(results_seen))
                0:       idle_pct = 52;
                1:       idle_pct = 7;
                default: idle_pct = 0;
            endcase
            rsp.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
                stall_cycles = 0;
            end
            else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("vertex_dedup_table_unit: mismatch");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        vertex_t planned[$];
        vertex_t v;
        int      roll;

        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.coord_x = '0;
        req.coord_y = '0;
        req.coord_z = '0;
        rsp.ready   = 1'b0;

        // Corners: extremes, single-bit near misses, and hits on old entries.
        planned = '{
            {16'sh0000, 16'sh0000, 16'sh0000},
            {16'sh0000, 16'sh0000, 16'sh0000},
            {COORD_MIN, COORD_MIN, COORD_MIN},
            {COORD_MAX, COORD_MAX, COORD_MAX},
            {16'shFFFF, 16'shFFFF, 16'shFFFF},
            {COORD_MAX, COORD_MIN, 16'sh0000},
            {COORD_MIN, COORD_MAX, 16'shFFFF},
            {16'sh0000, 16'sh0000, 16'sh0001},
            {16'sh0000, 16'sh0001, 16'sh0000},
            {16'sh0001, 16'sh0000, 16'sh0000},
            {COORD_MIN, COORD_MIN, 16'sh8001},
            {COORD_MAX, COORD_MAX, 16'sh7FFE},
            {16'sh0000, 16'sh0000, COORD_MIN},
            {16'sh0000, COORD_MIN, 16'sh0000},
            {COORD_MIN, 16'sh0000, 16'sh0000},
            {COORD_MAX, COORD_MAX, COORD_MAX},
            {16'shFFFF, 16'shFFFF, 16'shFFFF},
            {16'sh0001, 16'sh0000, 16'sh0000},
            {16'sh0000, 16'sh0000, 16'sh0000},
            {16'sh0000, 16'shFFFF, 16'shFFFF},
            {COORD_MIN, COORD_MAX, 16'shFFFF}
        };
        foreach (planned[i]) vertex_backlog.push_back(planned[i]);

        // About two thirds of the random beats are new vertices, so the table
        // fills partway through and the rest exercises the full case.
        repeat (RANDOM_BEATS) begin
            roll = $urandom_range(99);
            if (roll < 35) begin
                v = planned[$urandom_range(planned.size() - 1)];
            end
            else if (roll < 50) begin
                v = planned[$urandom_range(planned.size() - 1)]
                    ^ (vertex_t'(1) << $urandom_range(VERTEX_W - 1));
            end
            else begin
                v = {pick_coord(), pick_coord(), pick_coord()};
            end
            planned.push_back(v);
            vertex_backlog.push_back(v);
        end
        total_beats = vertex_backlog.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (vertex_backlog.size() != 0 || req.valid || expected_lookups.size() != 0)
            @(posedge clk);
        // Give any stray result beat a chance to show up.
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("vertex_dedup_table_unit: match");
        else
            $display("vertex_dedup_table_unit: mismatch");
        $finish;
    end

endmodule
